@@ rtl/next_permutation_stack_sort_check_macros.svh @@
// Assertion macros for the stack-sort check block.
// Used by the top level only; relies on clk and rst_n in the including scope.
`ifndef NEXT_PERMUTATION_STACK_SORT_CHECK_MACROS_SVH
`define NEXT_PERMUTATION_STACK_SORT_CHECK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NPSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/npsc_pkg.sv @@
// Shared types and constants of the stack-sort check block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package npsc_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int LEN_W       = 7;
    localparam int POS_W       = 6;
    localparam int VAL_W       = 7;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_TINIT,
        OP_TREAD,
        OP_TLATCH,
        OP_POP,
        OP_TOPLD,
        OP_PUSH,
        OP_PINIT,
        OP_PREAD,
        OP_PDEC,
        OP_PFOUND,
        OP_RREAD,
        OP_RDEC,
        OP_RFOUND,
        OP_SW1,
        OP_SW2,
        OP_VREAD,
        OP_VW1,
        OP_VW2
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic             n_lt2;
        logic             i_ge_n;
        logic             x_lt_s3;
        logic             pop_cond;
        logic             sp_zero;
        logic             p_found;
        logic             l_zero;
        logic             r_found;
        logic             a_lt_b;
        logic [POS_W-1:0] pivot;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/npsc_datapath.sv @@
// Datapath: permutation store, test stack, index registers and comparators.
// Depends on npsc_pkg; driven by npsc_ctrl through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module npsc_datapath #(
    parameter int MAX_LEN = npsc_pkg::MAX_LEN_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [npsc_pkg::LEN_W-1:0] cfg_wdata,
    input  wire logic [npsc_pkg::POS_W-1:0] ld_position,
    input  wire logic [npsc_pkg::VAL_W-1:0] ld_value,
    input  wire npsc_pkg::dp_cmd_t          cmd,
    output npsc_pkg::dp_status_t            status
);
    import npsc_pkg::*;

    // Lengths never exceed 127, so entries beyond 128 could never be reached.
    localparam int DEPTH = (MAX_LEN < 128) ? MAX_LEN : 128;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [VAL_W-1:0] perm_mem [DEPTH];
    logic [VAL_W-1:0] stk_mem  [DEPTH];

    logic [LEN_W-1:0] length_reg;
    logic [CW-1:0]    i_reg, i_next;
    logic [CW-1:0]    l_reg, l_next;
    logic [CW-1:0]    r_reg, r_next;
    logic [CW-1:0]    a_reg, a_next;
    logic [CW-1:0]    b_reg, b_next;
    logic [CW-1:0]    sp_reg, sp_next;
    logic [VAL_W-1:0] x_reg, x_next;
    logic [VAL_W-1:0] s3_reg, s3_next;
    logic [VAL_W-1:0] top_reg, top_next;
    logic             top_valid_reg, top_valid_next;
    logic [VAL_W-1:0] pl_reg, pl_next;
    logic [VAL_W-1:0] pr_reg, pr_next;

    logic [VAL_W-1:0] rd_a_reg, rd_b_reg, stk_rd_reg;

    logic [7:0]       n8;
    logic [CW-1:0]    n;
    logic             p_we, p_re;
    logic [IW-1:0]    p_wa, p_ra_a, p_ra_b;
    logic [VAL_W-1:0] p_wd;
    logic             s_we, s_re;
    logic [IW-1:0]    s_wa, s_ra;

    assign n8 = (8'(length_reg) > 8'(DEPTH)) ? 8'(DEPTH) : 8'(length_reg);
    assign n  = CW'(n8);

    always_comb
    begin
        i_next         = i_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        sp_next        = sp_reg;
        x_next         = x_reg;
        s3_next        = s3_reg;
        top_next       = top_reg;
        top_valid_next = top_valid_reg;
        pl_next        = pl_reg;
        pr_next        = pr_reg;
        p_we   = 1'b0;
        p_re   = 1'b0;
        p_wa   = l_reg[IW-1:0];
        p_wd   = pr_reg;
        p_ra_a = i_reg[IW-1:0];
        p_ra_b = b_reg[IW-1:0];
        s_we   = 1'b0;
        s_re   = 1'b0;
        s_wa   = sp_reg[IW-1:0];
        s_ra   = IW'(sp_reg - CW'(1));
        unique case (cmd.op)
            OP_IDLE:
            begin
            end
            OP_LOAD:
            begin
                p_we = (8'(ld_position) < 8'(DEPTH));
                p_wa = IW'(8'(ld_position));
                p_wd = ld_value;
            end
            OP_TINIT:
            begin
                i_next         = '0;
                sp_next        = '0;
                s3_next        = '0;
                top_valid_next = 1'b0;
            end
            OP_TREAD:
            begin
                p_re   = 1'b1;
                p_ra_a = i_reg[IW-1:0];
            end
            OP_TLATCH:
            begin
                x_next = rd_a_reg;
            end
            OP_POP:
            begin
                s3_next = top_reg;
                if (sp_reg != '0)
                begin
                    s_re    = 1'b1;
                    sp_next = sp_reg - CW'(1);
                end
                else
                begin
                    top_valid_next = 1'b0;
                end
            end
            OP_TOPLD:
            begin
                top_next = stk_rd_reg;
            end
            OP_PUSH:
            begin
                if (top_valid_reg)
                begin
                    s_we    = 1'b1;
                    sp_next = sp_reg + CW'(1);
                end
                top_next       = x_reg;
                top_valid_next = 1'b1;
                i_next         = i_reg + CW'(1);
            end
            OP_PINIT:
            begin
                l_next = n - CW'(2);
            end
            OP_PREAD:
            begin
                p_re   = 1'b1;
                p_ra_a = l_reg[IW-1:0];
                p_ra_b = IW'(l_reg + CW'(1));
            end
            OP_PDEC:
            begin
                l_next = l_reg - CW'(1);
            end
            OP_PFOUND:
            begin
                pl_next = rd_a_reg;
                r_next  = n - CW'(1);
            end
            OP_RREAD:
            begin
                p_re   = 1'b1;
                p_ra_a = r_reg[IW-1:0];
            end
            OP_RDEC:
            begin
                r_next = r_reg - CW'(1);
            end
            OP_RFOUND:
            begin
                pr_next = rd_a_reg;
            end
            OP_SW1:
            begin
                p_we = 1'b1;
                p_wa = l_reg[IW-1:0];
                p_wd = pr_reg;
            end
            OP_SW2:
            begin
                p_we   = 1'b1;
                p_wa   = r_reg[IW-1:0];
                p_wd   = pl_reg;
                a_next = l_reg + CW'(1);
                b_next = n - CW'(1);
            end
            OP_VREAD:
            begin
                p_re   = 1'b1;
                p_ra_a = a_reg[IW-1:0];
                p_ra_b = b_reg[IW-1:0];
            end
            OP_VW1:
            begin
                p_we = 1'b1;
                p_wa = a_reg[IW-1:0];
                p_wd = rd_b_reg;
            end
            OP_VW2:
            begin
                p_we   = 1'b1;
                p_wa   = b_reg[IW-1:0];
                p_wd   = rd_a_reg;
                a_next = a_reg + CW'(1);
                b_next = b_reg - CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= LEN_W'(1);
            top_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                length_reg <= cfg_wdata;
            end
            top_valid_reg <= top_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        l_reg   <= l_next;
        r_reg   <= r_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        sp_reg  <= sp_next;
        x_reg   <= x_next;
        s3_reg  <= s3_next;
        top_reg <= top_next;
        pl_reg  <= pl_next;
        pr_reg  <= pr_next;
    end

    // Permutation store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            perm_mem[p_wa] <= p_wd;
        end
        if (p_re)
        begin
            rd_a_reg <= perm_mem[p_ra_a];
            rd_b_reg <= perm_mem[p_ra_b];
        end
    end

    // Stack body for the pattern test; its top lives in top_reg.
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            stk_mem[s_wa] <= top_reg;
        end
        if (s_re)
        begin
            stk_rd_reg <= stk_mem[s_ra];
        end
    end

    assign status.n_lt2    = (n < CW'(2));
    assign status.i_ge_n   = (i_reg >= n);
    assign status.x_lt_s3  = (rd_a_reg < s3_reg);
    assign status.pop_cond = top_valid_reg && (top_reg < x_reg);
    assign status.sp_zero  = (sp_reg == '0);
    assign status.p_found  = (rd_a_reg < rd_b_reg);
    assign status.l_zero   = (l_reg == '0);
    assign status.r_found  = (pl_reg < rd_a_reg);
    assign status.a_lt_b   = (a_reg < b_reg);
    assign status.pivot    = POS_W'(l_reg);

endmodule

`default_nettype wire

@@ rtl/npsc_ctrl.sv @@
// Controller: sequences the pattern test and the successor step, holds the result beat.
// Depends on npsc_pkg; commands npsc_datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module npsc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_func,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      out_sortable,
    output logic                      out_advanced,
    output logic [npsc_pkg::POS_W-1:0] out_pivot,
    output npsc_pkg::dp_cmd_t         cmd,
    input  wire npsc_pkg::dp_status_t status
);
    import npsc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_T_RD, S_T_CHK, S_T_POP, S_T_POPW, S_A_START, S_P_RD, S_P_CHK,
        S_R_RD, S_R_CHK, S_SW1, S_SW2, S_V_CHK, S_V_W1, S_V_W2
    } state_t;

    state_t           state_reg, state_next;
    logic             sortable_reg, sortable_next;
    logic             out_valid_reg;
    logic             out_sortable_reg, out_advanced_reg;
    logic [POS_W-1:0] out_pivot_reg;
    logic             fin, fin_sort, fin_adv;
    logic             in_fire;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        sortable_next = sortable_reg;
        cmd.op        = OP_IDLE;
        fin           = 1'b0;
        fin_sort      = sortable_reg;
        fin_adv       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_func)
                    begin
                        cmd.op     = OP_TINIT;
                        state_next = S_T_RD;
                    end
                    else
                    begin
                        cmd.op   = OP_LOAD;
                        fin      = 1'b1;
                        fin_sort = 1'b0;
                    end
                end
            end
            S_T_RD:
            begin
                if (status.i_ge_n)
                begin
                    sortable_next = 1'b1;
                    state_next    = S_A_START;
                end
                else
                begin
                    cmd.op     = OP_TREAD;
                    state_next = S_T_CHK;
                end
            end
            S_T_CHK:
            begin
                // A value below the last popped one closes a 231 pattern.
                if (status.x_lt_s3)
                begin
                    sortable_next = 1'b0;
                    state_next    = S_A_START;
                end
                else
                begin
                    cmd.op     = OP_TLATCH;
                    state_next = S_T_POP;
                end
            end
            S_T_POP:
            begin
                if (status.pop_cond)
                begin
                    cmd.op     = OP_POP;
                    state_next = status.sp_zero ? S_T_POP : S_T_POPW;
                end
                else
                begin
                    cmd.op     = OP_PUSH;
                    state_next = S_T_RD;
                end
            end
            S_T_POPW:
            begin
                cmd.op     = OP_TOPLD;
                state_next = S_T_POP;
            end
            S_A_START:
            begin
                if (status.n_lt2)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_PINIT;
                    state_next = S_P_RD;
                end
            end
            S_P_RD:
            begin
                cmd.op     = OP_PREAD;
                state_next = S_P_CHK;
            end
            S_P_CHK:
            begin
                if (status.p_found)
                begin
                    cmd.op     = OP_PFOUND;
                    state_next = S_R_RD;
                end
                else if (status.l_zero)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_PDEC;
                    state_next = S_P_RD;
                end
            end
            S_R_RD:
            begin
                cmd.op     = OP_RREAD;
                state_next = S_R_CHK;
            end
            S_R_CHK:
            begin
                if (status.r_found)
                begin
                    cmd.op     = OP_RFOUND;
                    state_next = S_SW1;
                end
                else
                begin
                    cmd.op     = OP_RDEC;
                    state_next = S_R_RD;
                end
            end
            S_SW1:
            begin
                cmd.op     = OP_SW1;
                state_next = S_SW2;
            end
            S_SW2:
            begin
                cmd.op     = OP_SW2;
                state_next = S_V_CHK;
            end
            S_V_CHK:
            begin
                if (status.a_lt_b)
                begin
                    cmd.op     = OP_VREAD;
                    state_next = S_V_W1;
                end
                else
                begin
                    fin        = 1'b1;
                    fin_adv    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_V_W1:
            begin
                cmd.op     = OP_VW1;
                state_next = S_V_W2;
            end
            S_V_W2:
            begin
                cmd.op     = OP_VW2;
                state_next = S_V_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sortable_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_sortable_reg <= 1'b0;
            out_advanced_reg <= 1'b0;
            out_pivot_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            sortable_reg <= sortable_next;
            if (fin)
            begin
                out_valid_reg    <= 1'b1;
                out_sortable_reg <= fin_sort;
                out_advanced_reg <= fin_adv;
                out_pivot_reg    <= fin_adv ? status.pivot : '0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_sortable = out_sortable_reg;
    assign out_advanced = out_advanced_reg;
    assign out_pivot    = out_pivot_reg;

endmodule

`default_nettype wire

@@ rtl/next_permutation_stack_sort_check.sv @@
// Timing: a load beat gives its result beat in the cycle after acceptance. For a step beat
// the test scans the store with an explicit stack, then pivot search, swap and suffix
// reversal run through the store's single write port and registered reads. One item is
// in flight at a time.
// Reset: controller idle, length register 1; the store is not cleared and holds
// undefined contents until written.
`timescale 1ns / 1ps
`default_nettype none

`include "next_permutation_stack_sort_check_macros.svh"

module next_permutation_stack_sort_check #(
    parameter int MAX_LEN = npsc_pkg::MAX_LEN_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [npsc_pkg::LEN_W-1:0] cfg_wdata,     // length
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [15:0]                s_axis_tdata,  // position[5:0], element_value[12:6]
    input  wire logic [0:0]                 s_axis_tuser,  // func[0]
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [7:0]                      m_axis_tdata   // sortable[0], advanced[1], pivot[7:2]
);
    import npsc_pkg::*;

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic             out_sortable, out_advanced;
    logic [POS_W-1:0] out_pivot;

    npsc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_func      (s_axis_tuser[0]),
        .in_ready     (s_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_sortable (out_sortable),
        .out_advanced (out_advanced),
        .out_pivot    (out_pivot),
        .cmd          (cmd),
        .status       (status)
    );

    npsc_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .ld_position (s_axis_tdata[5:0]),
        .ld_value    (s_axis_tdata[12:6]),
        .cmd         (cmd),
        .status      (status)
    );

    assign m_axis_tdata = {out_pivot, out_advanced, out_sortable};

    `NPSC_ASSERT_NOW(a_load_on_accept, (cmd.op == OP_LOAD), (s_axis_tvalid && s_axis_tready), "store written without an accepted load beat")
    `NPSC_ASSERT_NEXT(a_step_busy, (s_axis_tvalid && s_axis_tready && s_axis_tuser[0]), (!m_axis_tvalid && !s_axis_tready), "step beat did not occupy the block")
    `NPSC_ASSERT_NEXT(a_load_result, (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0]), (m_axis_tvalid && (m_axis_tdata == 8'd0)), "load beat gave no zero result")

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for next_permutation_stack_sort_check: it drives load and step beats
// and predicts the stack-sortability flag and the successor pivot of every step.
// Depends on rtl/npsc_pkg.sv and the top level of the block.
`timescale 1ns / 1ps

module testbench;
    import npsc_pkg::*;

    typedef enum bit {FN_LOAD = 1'b0, FN_STEP = 1'b1} func_t;

    typedef struct {
        func_t               func;
        logic [POS_W-1:0]    pos;
        logic [VAL_W-1:0]    val;
    } perm_item_t;

    typedef struct {
        logic             sortable;
        logic             advanced;
        logic [POS_W-1:0] pivot;
    } step_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [LEN_W-1:0]    cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata;  // position[5:0], element_value[12:6]
    logic [0:0]          s_axis_tuser;  // func[0]
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [7:0]          m_axis_tdata;  // sortable[0], advanced[1], pivot[7:2]

    perm_item_t   pending_items[$];
    step_result_t expected_results[$];
    perm_item_t   beat_on_bus;

    logic [VAL_W-1:0] model_perm[MAX_LEN_DEF];
    int unsigned      model_length;

    int  accepted_count;
    int  mismatch_count;
    int  hold_cnt;
    bit  hold_done;
    int  sender_pct;
    int  receiver_pct;
    int  generated;

    next_permutation_stack_sort_check u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("testbench failed");
        $finish;
    end

    // Applies one beat to the local copy of the store and returns what the block should answer.
    function automatic step_result_t apply_item(perm_item_t it);
        step_result_t res;
        int unsigned  n;
        int           i;
        int           j;
        int           k;
        int           l;
        int           r;
        int           later_min;
        logic [VAL_W-1:0] t;
        res = '{1'b0, 1'b0, '0};
        if (it.func == FN_LOAD)
        begin
            model_perm[it.pos] = it.val;
            return res;
        end
        n = (model_length > MAX_LEN_DEF) ? MAX_LEN_DEF : model_length;
        res.sortable = 1'b1;
        for (j = 1; j + 1 < n; j++)
        begin
            later_min = 255;
            for (k = j + 1; k < n; k++)
                if (model_perm[k] < later_min)
                    later_min = model_perm[k];
            for (i = 0; i < j; i++)
                if (model_perm[i] < model_perm[j] && model_perm[i] > later_min)
                    res.sortable = 1'b0;
        end
        if (n >= 2)
        begin
            for (l = n - 2; l >= 0; l--)
                if (model_perm[l] < model_perm[l + 1])
                    break;
            if (l >= 0)
            begin
                r = n - 1;
                while (r > l && !(model_perm[l] < model_perm[r]))
                    r--;
                t = model_perm[l];
                model_perm[l] = model_perm[r];
                model_perm[r] = t;
                i = l + 1;
                j = n - 1;
                while (i < j)
                begin
                    t = model_perm[i];
                    model_perm[i] = model_perm[j];
                    model_perm[j] = t;
                    i++;
                    j--;
                end
                res.advanced = 1'b1;
                res.pivot = l[POS_W-1:0];
            end
        end
        return res;
    endfunction

    // Idling mix follows progress: sender idles lightly first, then the receiver, then nobody.
    always_comb
    begin
        if (accepted_count < 700)
        begin
            sender_pct = 9;
            receiver_pct = 47;
        end
        else if (accepted_count < 1400)
        begin
            sender_pct = 47;
            receiver_pct = 9;
        end
        else
        begin
            sender_pct = 0;
            receiver_pct = 0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            accepted_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(apply_item(beat_on_bus));
                accepted_count <= accepted_count + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_pct)
                begin
                    beat_on_bus = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {3'b000, beat_on_bus.val, beat_on_bus.pos};
                    s_axis_tuser <= beat_on_bus.func;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once, so that the block backs up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted_count == 200)
        begin
            hold_cnt <= 400;
            hold_done <= 1'b1;
        end
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            mismatch_count <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected result beat %h", m_axis_tdata);
                end
                else
                begin
                    step_result_t want;
                    want = expected_results.pop_front();
                    if (m_axis_tdata[0] !== want.sortable || m_axis_tdata[1] !== want.advanced
                        || m_axis_tdata[7:2] !== want.pivot)
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("mismatch: expected sortable %0d advanced %0d pivot %0d, got sortable %0d advanced %0d pivot %0d",
                                     want.sortable, want.advanced, want.pivot,
                                     m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[7:2]);
                    end
                end
            end
            m_axis_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= receiver_pct);
        end
    end

    task automatic queue_item(func_t f, int p, int v);
        perm_item_t it;
        it.func = f;
        it.pos = p[POS_W-1:0];
        it.val = v[VAL_W-1:0];
        pending_items.push_back(it);
        generated++;
    endtask

    // Waits until every beat is through, lets a step that might still run finish, then writes.
    task automatic write_length(int value);
        wait (pending_items.size() == 0 && expected_results.size() == 0 && !s_axis_tvalid);
        repeat (11 * MAX_LEN_DEF + 20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value[LEN_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        model_length = value;
    endtask

    task automatic load_perm(int n);
        int vals[$];
        int i;
        int j;
        int t;
        for (i = 0; i < n; i++)
            vals.push_back(i + 1);
        for (i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = vals[i];
            vals[i] = vals[j];
            vals[j] = t;
        end
        for (i = 0; i < n; i++)
            queue_item(FN_LOAD, i, vals[i]);
    endtask

    initial
    begin
        int i;
        int n;
        int steps;
        int kind;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        model_length = 1;
        generated = 0;
        for (i = 0; i < MAX_LEN_DEF; i++)
            model_perm[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every store entry is written before any step can read it.
        for (i = 0; i < MAX_LEN_DEF; i++)
            queue_item(FN_LOAD, i, $urandom_range(1, 64));
        queue_item(FN_STEP, 0, 0);

        write_length(0);
        queue_item(FN_STEP, 63, 127);

        write_length(3);
        queue_item(FN_LOAD, 0, 2);
        queue_item(FN_LOAD, 1, 3);
        queue_item(FN_LOAD, 2, 1);
        queue_item(FN_STEP, 0, 0);
        queue_item(FN_LOAD, 0, 3);
        queue_item(FN_LOAD, 1, 2);
        queue_item(FN_LOAD, 2, 1);
        queue_item(FN_STEP, 0, 0);
        queue_item(FN_LOAD, 0, 2);
        queue_item(FN_LOAD, 1, 2);
        queue_item(FN_LOAD, 2, 1);
        queue_item(FN_STEP, 0, 0);
        queue_item(FN_LOAD, 0, 0);
        queue_item(FN_LOAD, 1, 127);
        queue_item(FN_LOAD, 2, 64);
        queue_item(FN_STEP, 0, 0);
        queue_item(FN_STEP, 0, 0);

        write_length(2);
        queue_item(FN_LOAD, 0, 1);
        queue_item(FN_LOAD, 1, 2);
        queue_item(FN_STEP, 0, 0);
        queue_item(FN_STEP, 0, 0);

        // Above the store size the length saturates.
        write_length(127);
        queue_item(FN_STEP, 0, 0);
        write_length(64);
        load_perm(64);
        queue_item(FN_STEP, 0, 0);
        queue_item(FN_STEP, 0, 0);

        while (generated < 1900)
        begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
                n = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
            else if (kind == 1)
                n = $urandom_range(0, 1) ? 0 : $urandom_range(9, 40);
            else
                n = $urandom_range(1, 8);
            write_length(n);
            if ($urandom_range(0, 4) != 0)
            begin
                load_perm(n > MAX_LEN_DEF ? MAX_LEN_DEF : n);
                steps = (n > 8) ? $urandom_range(1, 4) : $urandom_range(1, 30);
                for (i = 0; i < steps; i++)
                    queue_item(FN_STEP, $urandom_range(0, 63), $urandom_range(0, 127));
            end
            else
            begin
                steps = $urandom_range(4, 20);
                for (i = 0; i < steps; i++)
                    if ($urandom_range(0, 1))
                        queue_item(FN_LOAD, $urandom_range(0, 63), $urandom_range(0, 127));
                    else
                        queue_item(FN_STEP, $urandom_range(0, 63), $urandom_range(0, 127));
            end
        end

        wait (pending_items.size() == 0 && expected_results.size() == 0 && !s_axis_tvalid);
        repeat (11 * MAX_LEN_DEF + 20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
